// ----- rtl/rstat_pkg.sv -----
// rstat_pkg: widths, constants and the word types shared by the running stats tracker.
// No dependencies.
`default_nettype none
package rstat_pkg;

  localparam int SampleWidth = 16;
  localparam int WindowDepth = 5;
  localparam int CountWidth  = 32;
  localparam int FracBits    = 8;
  localparam int MeanWidth   = SampleWidth + FracBits;
  localparam int SumWidth    = SampleWidth + CountWidth;
  localparam int ValidWidth  = 3;
  localparam int StepWidth   = $clog2(MeanWidth + 1);
  localparam int FifoDepth   = 2;
  localparam int FifoPtrW    = $clog2(FifoDepth);

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [ValidWidth-1:0] ValidMax = ValidWidth'(WindowDepth);

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [WindowDepth-1:0][SampleWidth-1:0] window_t;

  // work handed from the front end to the divider
  typedef struct packed {
    logic signed [SumWidth-1:0] sum;
    logic [CountWidth-1:0]      count;
    sample_t                    max_value;
    sample_t                    min_value;
    window_t                    window;
    logic [ValidWidth-1:0]      recent_valid;
    logic                       count_saturated;
  } job_t;

  typedef struct packed {
    sample_t                     max_value;
    sample_t                     min_value;
    logic signed [MeanWidth-1:0] mean_q8;
    window_t                     window;
    logic [ValidWidth-1:0]       recent_valid;
    logic                        count_saturated;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/running_stats_tracker_top.sv -----
// running_stats_tracker_top: sample queue in, statistics queue out.
// An accepted push goes through the job queue, then take, load, 24 divide steps and finish to the output.
// The mean divider works one job at a time, one quotient bit per cycle, and finish waits for a free result slot;
// a two-word job queue lets the front take samples while the divider is busy.
// Reset (rst_ni low, async): count, sum, extremes and queues cleared; recent window not cleared.
// Depends on rstat_pkg, rstat_front, rstat_job_fifo, rstat_back.
`default_nettype none
module running_stats_tracker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] sample_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      max_value_o,
  output logic [15:0]      min_value_o,
  output logic [23:0]      mean_q8_o,
  output logic [15:0]      recent_0_o,
  output logic [15:0]      recent_1_o,
  output logic [15:0]      recent_2_o,
  output logic [15:0]      recent_3_o,
  output logic [15:0]      recent_4_o,
  output logic [2:0]       recent_valid_o,
  output logic             count_saturated_o
);

  rstat_pkg::job_t job_in, job_out;
  rstat_pkg::res_t res;
  logic            accept, job_empty, job_take, res_valid;

  assign accept = push && !full;

  rstat_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i),
    .job_o    (job_in)
  );

  rstat_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (job_in),
    .full_o  (full),
    .rd_i    (job_take),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  rstat_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!job_empty),
    .job_i       (job_out),
    .job_take_o  (job_take),
    .pop_i       (pop && !empty),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty             = !res_valid;
  assign max_value_o       = res.max_value;
  assign min_value_o       = res.min_value;
  assign mean_q8_o         = res.mean_q8;
  assign recent_0_o        = res.window[0];
  assign recent_1_o        = res.window[1];
  assign recent_2_o        = res.window[2];
  assign recent_3_o        = res.window[3];
  assign recent_4_o        = res.window[4];
  assign recent_valid_o    = res.recent_valid;
  assign count_saturated_o = res.count_saturated;

endmodule
`default_nettype wire

// ----- rtl/rstat_front.sv -----
// rstat_front: takes samples, updates count, sum, extremes and the recent window,
// and emits one job word per sample. Depends on rstat_pkg.
`default_nettype none
module rstat_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire rstat_pkg::sample_t     sample_i,
  output rstat_pkg::job_t             job_o
);

  logic [rstat_pkg::CountWidth-1:0]      count_q, count_d;
  logic signed [rstat_pkg::SumWidth-1:0] sum_q, sum_d;
  rstat_pkg::sample_t                    max_q, max_d, min_q, min_d;
  logic [rstat_pkg::ValidWidth-1:0]      valid_q, valid_d;
  rstat_pkg::window_t                    win_q, win_d;
  logic                                  first;
  logic                                  sat;

  always_comb begin
    sat     = (count_q == rstat_pkg::CountMax);
    first   = (count_q == '0);
    count_d = sat ? count_q : count_q + 1'b1;
    sum_d   = sat ? sum_q
                  : sum_q + rstat_pkg::SumWidth'(sample_i);
    max_d   = (first || (sample_i > max_q)) ? sample_i : max_q;
    min_d   = (first || (sample_i < min_q)) ? sample_i : min_q;
    valid_d = (valid_q == rstat_pkg::ValidMax) ? valid_q : valid_q + 1'b1;
    win_d   = {win_q[rstat_pkg::WindowDepth-2:0], sample_i};

    job_o.sum             = sum_d;
    job_o.count           = count_d;
    job_o.max_value       = max_d;
    job_o.min_value       = min_d;
    job_o.window          = win_d;
    job_o.recent_valid    = valid_d;
    job_o.count_saturated = (count_d == rstat_pkg::CountMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      valid_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      min_q   <= min_d;
      valid_q <= valid_d;
    end
  end

  // window is payload and has no reset; recent_valid tells how many of its entries hold samples
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rstat_job_fifo.sv -----
// rstat_job_fifo: short job queue between the front end and the divider.
// Depends on rstat_pkg.
`default_nettype none
module rstat_job_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire rstat_pkg::job_t   wdata_i,
  output logic                   full_o,
  input  wire logic              rd_i,
  output rstat_pkg::job_t        rdata_o,
  output logic                   empty_o
);

  rstat_pkg::job_t mem_q [rstat_pkg::FifoDepth];
  logic [rstat_pkg::FifoPtrW-1:0] wptr_q, rptr_q;
  logic [rstat_pkg::FifoPtrW:0]   cnt_q;
  logic                           do_wr, do_rd;

  assign full_o  = (cnt_q == (rstat_pkg::FifoPtrW+1)'(rstat_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      if (do_wr && !do_rd)      cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rstat_back.sv -----
// rstat_back: restoring divider for the Q8 mean, one quotient bit per cycle,
// plus the result register. Depends on rstat_pkg.
`default_nettype none
module rstat_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_avail_i,
  input  wire rstat_pkg::job_t   job_i,
  output logic                   job_take_o,
  input  wire logic              pop_i,
  output logic                   res_valid_o,
  output rstat_pkg::res_t        res_o
);

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StDiv,
    StDone
  } state_e;

  state_e                                 state_q;
  rstat_pkg::job_t                        job_q;
  logic [rstat_pkg::CountWidth-1:0]       rem_q;
  logic [rstat_pkg::MeanWidth-1:0]        quo_q;
  logic [rstat_pkg::StepWidth-1:0]        step_q;
  logic                                   res_valid_q;
  rstat_pkg::res_t                        res_q;

  logic [rstat_pkg::SumWidth-1:0]         mag;
  logic [rstat_pkg::CountWidth:0]         trial, diff;
  logic                                   fits;
  logic                                   slot_free;
  logic signed [rstat_pkg::MeanWidth-1:0] mean;

  always_comb begin
    mag   = job_q.sum[rstat_pkg::SumWidth-1] ? -job_q.sum : job_q.sum;
    trial = {rem_q, quo_q[rstat_pkg::MeanWidth-1]};
    diff  = trial - {1'b0, job_q.count};
    fits  = !diff[rstat_pkg::CountWidth];
    mean  = job_q.sum[rstat_pkg::SumWidth-1] ? -quo_q : quo_q;
  end

  assign slot_free   = !res_valid_q || pop_i;
  assign job_take_o  = (state_q == StIdle) && job_avail_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      // a finished word replaces the one popped in the same cycle
      if ((state_q == StDone) && slot_free) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (job_avail_i) state_q <= StLoad;
        end
        StLoad: begin
          step_q  <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          step_q <= step_q + 1'b1;
          if (step_q == rstat_pkg::StepWidth'(rstat_pkg::MeanWidth - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (slot_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (job_avail_i) job_q <= job_i;
      end
      StLoad: begin
        // |sum|*256 / count is below 2^MeanWidth, so the top bits start below count
        rem_q <= mag[rstat_pkg::SumWidth-1:rstat_pkg::SampleWidth];
        quo_q <= {mag[rstat_pkg::SampleWidth-1:0], {rstat_pkg::FracBits{1'b0}}};
      end
      StDiv: begin
        rem_q <= fits ? diff[rstat_pkg::CountWidth-1:0] : trial[rstat_pkg::CountWidth-1:0];
        quo_q <= {quo_q[rstat_pkg::MeanWidth-2:0], fits};
      end
      StDone: begin
        if (slot_free) begin
          res_q.max_value       <= job_q.max_value;
          res_q.min_value       <= job_q.min_value;
          res_q.mean_q8         <= mean;
          res_q.window          <= job_q.window;
          res_q.recent_valid    <= job_q.recent_valid;
          res_q.count_saturated <= job_q.count_saturated;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
